[hdl/nnt_pkg.sv]
// ----------------------------------------------------------------------------
// nnt_pkg: shared definitions for the nearest neighbor tour unit
// Sizes, register codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_CITIES  = 16;
  localparam int MIN_CITIES  = 3;
  localparam int CITY_W      = $clog2(MAX_CITIES);
  localparam int CNT_W       = $clog2(MAX_CITIES + 1);
  localparam int STORE_DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = ADDR_W + 1;

  localparam int DIST_W      = 8;
  localparam int TOTAL_W     = 12;
  localparam int CITY_OUT_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int COUNT_REG_W = 5;
  localparam int START_REG_W = 4;
  localparam int LIMIT_REG_W = 8;

  localparam logic [COUNT_REG_W-1:0] COUNT_RST = 5'd12;
  localparam logic [START_REG_W-1:0] START_RST = 4'd0;
  localparam logic [LIMIT_REG_W-1:0] LIMIT_RST = 8'd99;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CITY_COUNT     = 2'd0,
    CFG_START_CITY     = 2'd1,
    CFG_DISTANCE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_SCAN,
    ST_DECIDE,
    ST_RET_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // store the accepted entry
    logic init;      // set up the walk, emit the start city
    logic row;       // mark current city visited, open its row
    logic scan;      // stream one row entry through the compare
    logic step;      // move to the best city, emit it
    logic ret_read;  // fetch the return-leg entry
    logic ret_emit;  // add return leg, emit closing beat
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic found;
  } status_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [DIST_W-1:0]  b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(b);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

endpackage

[hdl/nnt_ram.sv]
// ----------------------------------------------------------------------------
// nnt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/nnt_datapath.sv]
// ----------------------------------------------------------------------------
// nnt_datapath: matrix store, config registers, row scan and tour totals
// Executes controller commands; reports scan completion and hit status.
// ----------------------------------------------------------------------------
module nnt_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nnt_pkg::cmd_t                        cmd,
  output nnt_pkg::status_t                     status,
  input  logic [nnt_pkg::DIST_W-1:0]           in_distance,
  input  logic                                 cfg_we,
  input  logic [nnt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nnt_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  output logic [nnt_pkg::CITY_OUT_W-1:0]       out_city,
  output logic [nnt_pkg::TOTAL_W-1:0]          out_total_cost,
  output logic                                 out_tour_end
);

  localparam int CITY_W = nnt_pkg::CITY_W;
  localparam int CNT_W  = nnt_pkg::CNT_W;
  localparam int ADDR_W = nnt_pkg::ADDR_W;
  localparam int POS_W  = nnt_pkg::POS_W;
  localparam int DIST_W = nnt_pkg::DIST_W;
  localparam int TOT_W  = nnt_pkg::TOTAL_W;
  localparam int NN_W   = 2 * CNT_W;

  // config registers
  logic [nnt_pkg::COUNT_REG_W-1:0] city_count_r;
  logic [nnt_pkg::START_REG_W-1:0] start_city_r;
  logic [nnt_pkg::LIMIT_REG_W-1:0] limit_r;

  // walk state
  logic [POS_W-1:0]              load_pos_r;
  logic [nnt_pkg::MAX_CITIES-1:0] visited_r;
  logic [CITY_W-1:0]             cur_r;
  logic [CITY_W-1:0]             start_r;
  logic [TOT_W-1:0]              total_r;
  logic [ADDR_W-1:0]             row_base_r;
  logic [CNT_W-1:0]              scan_i_r;
  logic                          eval_v_r;
  logic [CITY_W-1:0]             eval_idx_r;
  logic                          found_r;
  logic [DIST_W-1:0]             best_d_r;
  logic [CITY_W-1:0]             best_r;

  // output beat
  logic                          out_valid_r;
  logic [CITY_W-1:0]             out_city_r;
  logic [TOT_W-1:0]              out_total_r;
  logic                          out_end_r;

  logic [CNT_W-1:0]  n_eff;
  logic [NN_W-1:0]   nn;
  logic [CITY_W-1:0] start_eff;
  logic              issue;
  logic              hit;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DIST_W-1:0] rd_data;
  logic              wr_en;
  logic [TOT_W-1:0]  step_total;
  logic [TOT_W-1:0]  ret_total;

  // clamp city count to the supported range
  always_comb begin
    if (int'(city_count_r) < nnt_pkg::MIN_CITIES) begin
      n_eff = CNT_W'(nnt_pkg::MIN_CITIES);
    end else if (int'(city_count_r) > nnt_pkg::MAX_CITIES) begin
      n_eff = CNT_W'(nnt_pkg::MAX_CITIES);
    end else begin
      n_eff = CNT_W'(city_count_r);
    end
  end

  assign nn        = NN_W'(n_eff) * NN_W'(n_eff);
  assign start_eff = (int'(start_city_r) < int'(n_eff)) ? CITY_W'(start_city_r) : '0;

  assign wr_en = cmd.load && (POS_W'(load_pos_r) < POS_W'(nn));
  assign issue = cmd.scan && (scan_i_r < n_eff);
  assign rd_en = issue || cmd.ret_read;

  always_comb begin
    if (cmd.ret_read) begin
      rd_addr = row_base_r + ADDR_W'(start_r);
    end else begin
      rd_addr = row_base_r + ADDR_W'(scan_i_r);
    end
  end

  nnt_ram #(
    .WIDTH (DIST_W),
    .DEPTH (nnt_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_pos_r[ADDR_W-1:0]),
    .wr_data (in_distance),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // candidate test: strict less-than keeps the lowest index on ties
  assign hit = eval_v_r && !visited_r[eval_idx_r] && (rd_data != '0) &&
               (rd_data < limit_r) && (!found_r || (rd_data < best_d_r));

  assign step_total = nnt_pkg::sat_add(total_r, best_d_r);
  assign ret_total  = nnt_pkg::sat_add(total_r, rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= nnt_pkg::COUNT_RST;
      start_city_r <= nnt_pkg::START_RST;
      limit_r      <= nnt_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nnt_pkg::CFG_CITY_COUNT: begin
          city_count_r <= cfg_data[nnt_pkg::COUNT_REG_W-1:0];
        end
        nnt_pkg::CFG_START_CITY: begin
          start_city_r <= cfg_data[nnt_pkg::START_REG_W-1:0];
        end
        nnt_pkg::CFG_DISTANCE_LIMIT: begin
          limit_r <= cfg_data[nnt_pkg::LIMIT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r  <= '0;
      visited_r   <= '0;
      cur_r       <= '0;
      total_r     <= '0;
      eval_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      eval_v_r    <= issue;

      if (wr_en) begin
        load_pos_r <= load_pos_r + 1'b1;
      end

      if (cmd.init) begin
        cur_r       <= start_eff;
        start_r     <= start_eff;
        total_r     <= '0;
        visited_r   <= '0;
        out_valid_r <= 1'b1;
        out_city_r  <= start_eff;
        out_total_r <= '0;
        out_end_r   <= 1'b0;
      end

      if (cmd.row) begin
        visited_r[cur_r] <= 1'b1;
        row_base_r       <= ADDR_W'(ADDR_W'(cur_r) * ADDR_W'(n_eff));
        scan_i_r         <= '0;
        found_r          <= 1'b0;
      end

      if (issue) begin
        eval_idx_r <= scan_i_r[CITY_W-1:0];
        scan_i_r   <= scan_i_r + 1'b1;
      end

      if (hit) begin
        found_r  <= 1'b1;
        best_d_r <= rd_data;
        best_r   <= eval_idx_r;
      end

      if (cmd.step) begin
        total_r     <= step_total;
        cur_r       <= best_r;
        out_valid_r <= 1'b1;
        out_city_r  <= best_r;
        out_total_r <= step_total;
        out_end_r   <= 1'b0;
      end

      if (cmd.ret_emit) begin
        total_r     <= ret_total;
        load_pos_r  <= '0;
        out_valid_r <= 1'b1;
        out_city_r  <= start_r;
        out_total_r <= ret_total;
        out_end_r   <= 1'b1;
      end
    end
  end

  assign status.scan_done = (scan_i_r >= n_eff) && !eval_v_r;
  assign status.found     = found_r;

  assign out_valid      = out_valid_r;
  assign out_city       = nnt_pkg::CITY_OUT_W'(out_city_r);
  assign out_total_cost = out_total_r;
  assign out_tour_end   = out_end_r;

endmodule

[hdl/nnt_ctrl.sv]
// ----------------------------------------------------------------------------
// nnt_ctrl: tour sequencer
// Steps load, init, row scan, decide and return-leg phases of the walk.
// ----------------------------------------------------------------------------
module nnt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             last_entry,
  input  nnt_pkg::status_t status,
  output nnt_pkg::cmd_t    cmd,
  output logic             busy
);

  nnt_pkg::state_t state_r;
  nnt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      nnt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (last_entry) begin
            state_nxt = nnt_pkg::ST_INIT;
          end
        end
      end
      nnt_pkg::ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = nnt_pkg::ST_ROW;
      end
      nnt_pkg::ST_ROW: begin
        cmd.row   = 1'b1;
        state_nxt = nnt_pkg::ST_SCAN;
      end
      nnt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = nnt_pkg::ST_DECIDE;
        end
      end
      nnt_pkg::ST_DECIDE: begin
        if (status.found) begin
          cmd.step  = 1'b1;
          state_nxt = nnt_pkg::ST_ROW;
        end else begin
          cmd.ret_read = 1'b1;
          state_nxt    = nnt_pkg::ST_RET_EMIT;
        end
      end
      nnt_pkg::ST_RET_EMIT: begin
        cmd.ret_emit = 1'b1;
        state_nxt    = nnt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = nnt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/nearest_neighbor_tour_unit.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_unit: greedy nearest-neighbor tour over a loaded matrix
// Loads an N x N distance matrix row-major, then walks a greedy tour from
// the start city and streams each visited city with its running cost.
// ----------------------------------------------------------------------------
// Loading: one matrix beat per cycle, busy stays low between entries.
// Walk: after the last-entry beat busy rises; each row searched takes the
//   steps row open, N reads through the store's single read port, read
//   drain, scan-done and decide; one beat for the start city, one per hop
//   and one closing beat, each on out_valid for one cycle.
// The receiver cannot stall: out_valid beats must be taken as they appear.
// Reset (rst_n low, synchronous): registers to 12 / 0 / 99, load position
//   and walk state cleared; the matrix store is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic [nnt_pkg::DIST_W-1:0]          in_distance,
  input  logic                                in_last_entry,
  // result channel
  output logic                                out_valid,
  output logic [nnt_pkg::CITY_OUT_W-1:0]      out_city,
  output logic [nnt_pkg::TOTAL_W-1:0]         out_total_cost,
  output logic                                out_tour_end,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nnt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nnt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  nnt_pkg::cmd_t    cmd;
  nnt_pkg::status_t status;

  // registers are always writable; software only writes while idle
  assign cfg_ready = 1'b1;

  // sequencer: accepts a beat only in its idle state (busy low)
  nnt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_entry (in_last_entry),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // store, scan compare, totals and registered result beat
  nnt_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_distance    (in_distance),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_city       (out_city),
    .out_total_cost (out_total_cost),
    .out_tour_end   (out_tour_end)
  );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for nearest_neighbor_tour_unit
// Streams distance matrices in over the start/busy channel and reprograms
// the registers between tours. A local greedy-walk model or the typed plan
// rows predict every tour beat, and each out_valid beat is checked in order against them.
// ----------------------------------------------------------------------------
module tb;
  import nnt_pkg::*;

  // index 3 decodes to no register; writes there must leave the setup alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 300000; // whole run, many times the slowest pass
  localparam int SETTLE_CYCLES = 4;      // settle margin after busy is low and no beats are owed
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 346;    // minimum number of entries sent in the random part

  typedef struct packed {
    logic [CITY_OUT_W-1:0] city;
    logic [TOTAL_W-1:0]    total;
    logic                  tour_end;
  } tour_beat_t;

  typedef enum logic [1:0] {
    ROW_REG,    // register write
    ROW_ENTRY,  // matrix entry, beats come from the model
    ROW_TYPED   // last entry of a dead-end tour, beats typed in the row
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [7:0]            value;
    logic                  last;
    logic [CITY_OUT_W-1:0] t_city;
    logic [TOTAL_W-1:0]    t_total;
  } plan_row_t;

  // DUT-facing signals; every input known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [DIST_W-1:0]      in_distance = '0;
  logic                   in_last_entry = 1'b0;
  logic                   out_valid;
  logic [CITY_OUT_W-1:0]  out_city;
  logic [TOTAL_W-1:0]     out_total_cost;
  logic                   out_tour_end;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // model copy of the registers (reset values)
  logic [COUNT_REG_W-1:0] cnt_reg   = COUNT_RST;
  logic [START_REG_W-1:0] start_reg = START_RST;
  logic [LIMIT_REG_W-1:0] limit_reg = LIMIT_RST;

  // model copy of the matrix store and the load pointer
  logic [DIST_W-1:0]      mtx [STORE_DEPTH];
  int                     fill_pos = 0;

  tour_beat_t             walk_beats[$];     // beats of the latest tour
  tour_beat_t             pending_beats[$];  // beats still owed by the DUT
  plan_row_t              plan[$];

  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  int                     beat_idx = 0;
  int                     burst_left = 0;
  int                     loaded_items = 0;

  nearest_neighbor_tour_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_distance    (in_distance),
    .in_last_entry  (in_last_entry),
    .out_valid      (out_valid),
    .out_city       (out_city),
    .out_total_cost (out_total_cost),
    .out_tour_end   (out_tour_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hang anywhere ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- model
  // city count is clamped into [MIN_CITIES, MAX_CITIES]
  function automatic int eff_cities();
    if (cnt_reg < MIN_CITIES) return MIN_CITIES;
    if (cnt_reg > MAX_CITIES) return MAX_CITIES;
    return cnt_reg;
  endfunction

  function automatic int cost_add(input int a, input int b);
    return (a + b > TOTAL_MAX) ? TOTAL_MAX : a + b;
  endfunction

  function automatic tour_beat_t make_beat(input int c, input int t, input logic e);
    tour_beat_t b;
    b.city     = CITY_OUT_W'(c);
    b.total    = TOTAL_W'(t);
    b.tour_end = e;
    return b;
  endfunction

  // Store one entry; on the last entry walk the greedy tour and leave its
  // beats in walk_beats.
  task automatic walk_tour(input logic [DIST_W-1:0] dval, input logic last);
    int n, org, here, nxt, best_d, cost, d;
    logic found;
    logic [MAX_CITIES-1:0] seen;
    n = eff_cities();
    walk_beats.delete();
    // entries past N*N are dropped, pointer parks at the end
    if (fill_pos < n * n) begin
      mtx[fill_pos] = dval;
      fill_pos++;
    end
    if (!last) return;
    // start city outside the matrix falls back to city 0
    org  = (start_reg < n) ? int'(start_reg) : 0;
    here = org;
    cost = 0;
    seen = '0;
    walk_beats.push_back(make_beat(here, cost, 1'b0));
    for (int hop = 0; hop < n; hop++) begin
      // current city marked before its row is searched: no self loops
      seen[here] = 1'b1;
      found  = 1'b0;
      best_d = 0;
      nxt    = 0;
      for (int i = 0; i < n; i++) begin
        d = mtx[here * n + i];
        // zero is no edge; strict < keeps the lowest index on ties
        if (!seen[i] && d != 0 && d < limit_reg && (!found || d < best_d)) begin
          found  = 1'b1;
          best_d = d;
          nxt    = i;
        end
      end
      if (!found) break;  // dead end: close the tour right away
      cost = cost_add(cost, best_d);
      here = nxt;
      walk_beats.push_back(make_beat(here, cost, 1'b0));
    end
    // return leg from the store as loaded; a zero entry adds nothing
    cost = cost_add(cost, mtx[here * n + org]);
    walk_beats.push_back(make_beat(org, cost, 1'b1));
    fill_pos = 0;
  endtask

  // ---------------------------------------------------------------- drivers
  // One entry beat. The beat is taken at the edge where start is high and
  // busy is low. Start stays high through a burst; between bursts it drops
  // for a random gap, so gaps land on loading and on every part of a walk.
  task automatic send_item(input logic [DIST_W-1:0] dval, input logic last,
                           input logic typed, input logic [CITY_OUT_W-1:0] t_city,
                           input logic [TOTAL_W-1:0] t_total);
    if (cfg_valid) cfg_valid <= 1'b0;
    start         <= 1'b1;
    in_distance   <= dval;
    in_last_entry <= last;
    do @(posedge clk); while (busy);
    loaded_items++;
    walk_tour(dval, last);
    if (typed) begin
      // dead end at the start: start city at zero, then the closing beat
      pending_beats.push_back(make_beat(t_city, 0, 1'b0));
      pending_beats.push_back(make_beat(t_city, t_total, 1'b1));
    end else begin
      foreach (walk_beats[k]) pending_beats.push_back(walk_beats[k]);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long run with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Quiesce: no entry offered, every owed beat seen, busy low, then settle.
  task automatic wait_idle();
    start <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    do @(posedge clk); while (busy || pending_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write. cfg_valid is left high so back-to-back writes stay one
  // assignment per edge; the next entry or idle wait lowers it.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      CFG_CITY_COUNT:     cnt_reg   = v[COUNT_REG_W-1:0];
      CFG_START_CITY:     start_reg = v[START_REG_W-1:0];
      CFG_DISTANCE_LIMIT: limit_reg = v[LIMIT_REG_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic void add_reg(input logic [CFG_IDX_W-1:0] r, input logic [7:0] v);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_REG;
    row.reg_idx = r;
    row.value   = v;
    plan.push_back(row);
  endfunction

  function automatic void add_entry(input logic [7:0] v, input logic last);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_ENTRY;
    row.value = v;
    row.last  = last;
    plan.push_back(row);
  endfunction

  function automatic void add_typed(input logic [7:0] v, input logic [CITY_OUT_W-1:0] c,
                                    input logic [TOTAL_W-1:0] t);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_TYPED;
    row.value   = v;
    row.last    = 1'b1;
    row.t_city  = c;
    row.t_total = t;
    plan.push_back(row);
  endfunction

  // Mix of no-edge, arbitrary, tie and in-range distances.
  function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] tie_val);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return DIST_W'($urandom);
    if (r < 45) return tie_val;
    if (limit_reg > 1) return DIST_W'($urandom_range(1, limit_reg - 1));
    return DIST_W'($urandom);
  endfunction

  // One random phase: maybe retune the registers while idle, then send a
  // sequence: a whole matrix (most of them when N is 9 or less), or one that
  // ends early, runs long past N*N, or stops without a last entry.
  task automatic run_phase(input bit first);
    int n, pick, len;
    logic closes;
    logic [7:0] data, tie_val;
    wait_idle();
    if (first || $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 99);
      if (first) n = MAX_CITIES;
      else if (pick < 70) n = $urandom_range(MIN_CITIES, 5);
      else if (pick < 90) n = $urandom_range(6, 9);
      else n = $urandom_range(10, MAX_CITIES);
      if (first || $urandom_range(0, 1)) begin
        // top bits are don't-care; out-of-range counts clamp
        data = {3'($urandom), 5'(n)};
        if (n == MIN_CITIES && $urandom_range(0, 2) == 0)
          data[4:0] = 5'($urandom_range(0, MIN_CITIES));
        if (n == MAX_CITIES && $urandom_range(0, 1) == 0)
          data[4:0] = 5'($urandom_range(MAX_CITIES, 31));
        cfg_write(CFG_CITY_COUNT, data);
      end
      if (first || $urandom_range(0, 1)) cfg_write(CFG_START_CITY, 8'($urandom));
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       data = 8'd0;
          1:       data = 8'd1;
          2:       data = 8'd255;
          3:       data = 8'($urandom);
          default: data = 8'($urandom_range(20, 200));
        endcase
        cfg_write(CFG_DISTANCE_LIMIT, data);
      end
    end
    n       = eff_cities();
    tie_val = (limit_reg > 1) ? 8'($urandom_range(1, limit_reg - 1)) : 8'($urandom);
    pick    = $urandom_range(0, 99);
    closes  = 1'b1;
    if (first || pick < (n <= 9 ? 65 : 8)) begin
      len = n * n;                                   // whole matrix
    end else if (pick < 80 || n > 9) begin
      len = $urandom_range(1, (n * n - 1 < 30) ? n * n - 1 : 30);  // early last
    end else if (pick < 92) begin
      len = n * n + $urandom_range(1, 5);            // extras get dropped
    end else begin
      len    = $urandom_range(1, 5);                 // partial load, no walk
      closes = 1'b0;
    end
    for (int k = 0; k < len; k++)
      send_item(pick_distance(tie_val), closes && (k == len - 1), 1'b0, '0, '0);
  endtask

  // ---------------------------------------------------------------- checker
  // Results cannot be held off, so each out_valid cycle is one beat.
  always @(posedge clk) begin : beat_check
    tour_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0d unexpected: city %0d total %0d end %0b",
                                  beat_idx, out_city, out_total_cost, out_tour_end));
      end else begin
        want = pending_beats.pop_front();
        if (out_city !== want.city)
          report_mismatch($sformatf("beat %0d city got %0d want %0d",
                                    beat_idx, out_city, want.city));
        if (out_total_cost !== want.total)
          report_mismatch($sformatf("beat %0d total_cost got %0d want %0d",
                                    beat_idx, out_total_cost, want.total));
        if (out_tour_end !== want.tour_end)
          report_mismatch($sformatf("beat %0d tour_end got %0b want %0b",
                                    beat_idx, out_tour_end, want.tour_end));
      end
      beat_idx++;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    // Directed part. All of it runs at three cities, so every store read
    // stays inside the first nine entries, written by the first matrix.
    add_reg(CFG_UNUSED, 8'hFF);          // no register behind this index
    add_reg(CFG_CITY_COUNT, 8'd0);       // below the minimum: three cities
    add_reg(CFG_DISTANCE_LIMIT, 8'd255); // widest limit
    // 0 -> tie at 5 goes to city 1 -> 254 just under the limit -> back 9;
    // 255 is never taken and the diagonal 3 is a self loop
    add_entry(8'd0, 1'b0);  add_entry(8'd5, 1'b0);   add_entry(8'd5, 1'b0);
    add_entry(8'd7, 1'b0);  add_entry(8'd0, 1'b0);   add_entry(8'd254, 1'b0);
    add_entry(8'd9, 1'b0);  add_entry(8'd255, 1'b0); add_entry(8'd3, 1'b1);
    // zero limit: stuck at city 2, return leg is its diagonal (3);
    // early last after two entries, the rest is the old matrix
    add_reg(CFG_DISTANCE_LIMIT, 8'd0);
    add_reg(CFG_START_CITY, 8'd2);
    add_entry(8'd40, 1'b0);
    add_typed(8'd50, 4'd2, 12'd3);
    // start past the matrix falls back to city 0; limit 1 blocks every edge;
    // the lone entry lands on the 0,0 diagonal and becomes the return leg
    add_reg(CFG_START_CITY, 8'd15);
    add_reg(CFG_DISTANCE_LIMIT, 8'd1);
    add_typed(8'd200, 4'd0, 12'd200);
    // nine entries, two surplus ones and a surplus last entry: all three
    // dropped, yet the last one still starts the walk
    add_reg(CFG_DISTANCE_LIMIT, 8'd99);
    add_reg(CFG_START_CITY, 8'd1);
    add_entry(8'd0, 1'b0);  add_entry(8'd12, 1'b0);  add_entry(8'd40, 1'b0);
    add_entry(8'd12, 1'b0); add_entry(8'd0, 1'b0);   add_entry(8'd98, 1'b0);
    add_entry(8'd99, 1'b0); add_entry(8'd30, 1'b0);  add_entry(8'd0, 1'b0);
    add_entry(8'd77, 1'b0); add_entry(8'd88, 1'b0);  add_entry(8'd66, 1'b1);

    // synchronous reset, applied once
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: begin
          wait_idle();
          cfg_write(plan[i].reg_idx, plan[i].value);
        end
        ROW_ENTRY: send_item(plan[i].value, plan[i].last, 1'b0, '0, '0);
        default:   send_item(plan[i].value, 1'b1, 1'b1, plan[i].t_city, plan[i].t_total);
      endcase
    end

    // Random part. A full 16 x 16 load comes first, so that every later
    // early last entry reads only entries that have been written.
    loaded_items = 0;
    run_phase(1'b1);
    while (loaded_items < RANDOM_ITEMS)
      run_phase(1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
